>>> rtl/apbg_pkg.sv
// Shared types, constants and helper functions for the partition bitmap generator.
package apbg_pkg;

    localparam int BLOCK_DIM  = 4;
    localparam int NUM_TEXELS = BLOCK_DIM * BLOCK_DIM;
    localparam int MAP_W      = 16;
    localparam int PART_MAX   = 4;
    localparam int SEED_W     = 10;
    localparam int CNT_W      = 3;
    localparam int USED_W     = 3;
    localparam int WGT_W      = 6;
    localparam int SQ_W       = 4;
    localparam int COORD_W    = $clog2(2 * BLOCK_DIM - 1);

    localparam logic [31:0] HASH_MUL = 32'hEEDE0891;

    // Bits of a map word that some texel can occupy.
    localparam logic [MAP_W-1:0] MAP_COVER =
        (NUM_TEXELS >= MAP_W) ? {MAP_W{1'b1}} : MAP_W'((64'd1 << NUM_TEXELS) - 64'd1);

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [SEED_W-1:0] seed;
    } item_t;

    // Hash rounds that follow the multiply.
    function automatic logic [31:0] mix_tail(input logic [31:0] p);
        logic [31:0] v;
        v = p ^ (p >> 5);
        v = v + (v << 16);
        v = v ^ (v >> 7);
        v = v ^ (v >> 3);
        v = v ^ (v << 6);
        v = v ^ (v >> 17);
        return v;
    endfunction

    // Squared nibble, kept to 8 bits, then shifted down.
    function automatic logic [SQ_W-1:0] sq_shift(input logic [3:0] n, input logic [2:0] sh);
        logic [7:0] sq;
        sq = 8'(n) * 8'(n);
        return SQ_W'(sq >> sh);
    endfunction

endpackage

>>> rtl/apbg_hash.sv
// Two-stage pipelined seed hash: multiply stage, then shift/xor rounds.
module apbg_hash (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  apbg_pkg::item_t      in_item,
    output logic                 out_valid,
    output apbg_pkg::item_t      out_item,
    output logic [31:0]          out_h
);

    logic            mul_valid_reg;
    apbg_pkg::item_t mul_item_reg;
    logic [31:0]     mul_prod_reg;
    logic [31:0]     mul_prod_next;
    logic [11:0]     hash_in;

    logic            h_valid_reg;
    apbg_pkg::item_t h_item_reg;
    logic [31:0]     h_reg;

    // seed + (cnt - 1) * 1024; the first xor-shift by 15 is a no-op on 12 bits
    always_comb begin
        hash_in       = {2'(in_item.cnt - 3'd1), in_item.seed};
        mul_prod_next = 32'(32'(hash_in) * apbg_pkg::HASH_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            h_valid_reg   <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            h_valid_reg   <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_item_reg <= in_item;
            mul_prod_reg <= mul_prod_next;
            h_item_reg   <= mul_item_reg;
            h_reg        <= apbg_pkg::mix_tail(mul_prod_reg);
        end
    end

    assign out_valid = h_valid_reg;
    assign out_item  = h_item_reg;
    assign out_h     = h_reg;

endmodule

>>> rtl/astc_partition_bitmap_gen.sv
// Top level: ASTC procedural partition bitmap generator pipeline.
//
// Input items arrive on s_axis_* (tdata: part_seed, part_total). Each item
// yields one result on m_axis_* (tdata: four texel bitmaps, used_parts,
// count_matches). The small_block_bias register is written through
// cfg_wdata by cfg_we; write it only while the block is idle (not enforced).
//
// Five register stages: hash multiply, hash rounds, seed squares, texel
// partition evaluation, result summary. Each accepted item passes through
// these registers in that order, and one item is taken every cycle while
// the receiver keeps m_axis_tready high.
//
// When the output register holds a result that is not taken, every stage
// holds and s_axis_tready drops; nothing is lost or repeated. Empty stages
// do not fill in under a stall.
//
// Reset (aresetn low, synchronous) empties the pipeline and sets
// small_block_bias to 1.
module astc_partition_bitmap_gen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,       // small_block_bias
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [9:0] part_seed, [12:10] part_total, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata     // [15:0] map_part0, [31:16] map_part1,
                                         // [47:32] map_part2, [63:48] map_part3,
                                         // [66:64] used_parts, [67] count_matches, rest zero
);

    localparam int PM = apbg_pkg::PART_MAX;

    logic                          bias_reg;
    logic                          en;
    apbg_pkg::item_t               in_item;
    logic [apbg_pkg::CNT_W-1:0]    cnt_raw;

    logic                          h_valid;
    apbg_pkg::item_t               h_item;
    logic [31:0]                   h_val;

    // seed-square stage
    logic                          sd_valid_reg;
    logic [apbg_pkg::CNT_W-1:0]    sd_cnt_reg;
    logic [apbg_pkg::SQ_W-1:0]     sd_sq_reg   [8];
    logic [apbg_pkg::SQ_W-1:0]     sd_sq_next  [8];
    logic [apbg_pkg::WGT_W-1:0]    sd_off_reg  [PM];
    logic [apbg_pkg::WGT_W-1:0]    sd_off_next [PM];
    logic [2:0]                    sh1, sh2, sh_alt, sh_seed;

    // texel stage
    logic                          tx_valid_reg;
    logic [apbg_pkg::CNT_W-1:0]    tx_cnt_reg;
    logic [apbg_pkg::MAP_W-1:0]    tx_map_reg  [PM];
    logic [apbg_pkg::MAP_W-1:0]    tx_map_next [PM];
    logic [PM-1:0]                 tx_occ_reg;
    logic [PM-1:0]                 tx_occ_next;

    // output stage
    logic                          out_valid_reg;
    logic [apbg_pkg::MAP_W-1:0]    out_map_reg [PM];
    logic [apbg_pkg::USED_W-1:0]   out_used_reg;
    logic [apbg_pkg::USED_W-1:0]   out_used_next;
    logic                          out_match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= 1'b1;
        end else if (cfg_we) begin
            bias_reg <= cfg_wdata;
        end
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // clamp the requested count to 1..4
    always_comb begin
        cnt_raw      = s_axis_tdata[12:10];
        in_item.seed = s_axis_tdata[9:0];
        if (cnt_raw == 3'd0) begin
            in_item.cnt = 3'd1;
        end else if (cnt_raw > 3'd4) begin
            in_item.cnt = 3'd4;
        end else begin
            in_item.cnt = cnt_raw;
        end
    end

    apbg_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (h_valid),
        .out_item  (h_item),
        .out_h     (h_val)
    );

    // seed squares; even nibbles take shift sh1 and odd nibbles take sh2
    always_comb begin
        sh_alt  = (h_item.cnt == 3'd3) ? 3'd6 : 3'd5;
        sh_seed = h_item.seed[1] ? 3'd4 : 3'd5;
        if (h_item.seed[0]) begin
            sh1 = sh_seed;
            sh2 = sh_alt;
        end else begin
            sh1 = sh_alt;
            sh2 = sh_seed;
        end
        for (int i = 0; i < 8; i++) begin
            sd_sq_next[i] = apbg_pkg::sq_shift(h_val[4*i +: 4], (i % 2 == 0) ? sh1 : sh2);
        end
        sd_off_next[0] = h_val[19:14];
        sd_off_next[1] = h_val[15:10];
        sd_off_next[2] = h_val[11:6];
        sd_off_next[3] = h_val[7:2];
    end

    // texel partition assignment, all texels side by side
    always_comb begin
        logic [apbg_pkg::COORD_W-1:0] cx, cy;
        logic [apbg_pkg::WGT_W-1:0]   w [PM];
        logic [1:0]                   p;
        int                           t;
        for (int k = 0; k < PM; k++) begin
            tx_map_next[k] = '0;
        end
        tx_occ_next = '0;
        for (int y = 0; y < apbg_pkg::BLOCK_DIM; y++) begin
            for (int x = 0; x < apbg_pkg::BLOCK_DIM; x++) begin
                t  = y * apbg_pkg::BLOCK_DIM + x;
                cx = bias_reg ? apbg_pkg::COORD_W'(2 * x) : apbg_pkg::COORD_W'(x);
                cy = bias_reg ? apbg_pkg::COORD_W'(2 * y) : apbg_pkg::COORD_W'(y);
                for (int k = 0; k < PM; k++) begin
                    w[k] = apbg_pkg::WGT_W'(6'(sd_sq_reg[2*k]) * 6'(cx))
                         + apbg_pkg::WGT_W'(6'(sd_sq_reg[2*k+1]) * 6'(cy))
                         + sd_off_reg[k];
                end
                if (sd_cnt_reg <= 3'd3) w[3] = '0;
                if (sd_cnt_reg <= 3'd2) w[2] = '0;
                if (sd_cnt_reg <= 3'd1) w[1] = '0;
                if (w[0] >= w[1] && w[0] >= w[2] && w[0] >= w[3]) begin
                    p = 2'd0;
                end else if (w[1] >= w[2] && w[1] >= w[3]) begin
                    p = 2'd1;
                end else if (w[2] >= w[3]) begin
                    p = 2'd2;
                end else begin
                    p = 2'd3;
                end
                tx_occ_next[p] = 1'b1;
                if (t < apbg_pkg::MAP_W) begin
                    tx_map_next[p][t] = 1'b1;
                end
            end
        end
    end

    // leading non-empty partitions
    always_comb begin
        if (!tx_occ_reg[0]) begin
            out_used_next = 3'd0;
        end else if (!tx_occ_reg[1]) begin
            out_used_next = 3'd1;
        end else if (!tx_occ_reg[2]) begin
            out_used_next = 3'd2;
        end else if (!tx_occ_reg[3]) begin
            out_used_next = 3'd3;
        end else begin
            out_used_next = 3'd4;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd_valid_reg  <= 1'b0;
            tx_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sd_valid_reg  <= h_valid;
            tx_valid_reg  <= sd_valid_reg;
            out_valid_reg <= tx_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_cnt_reg    <= h_item.cnt;
            sd_sq_reg     <= sd_sq_next;
            sd_off_reg    <= sd_off_next;
            tx_cnt_reg    <= sd_cnt_reg;
            tx_map_reg    <= tx_map_next;
            tx_occ_reg    <= tx_occ_next;
            out_map_reg   <= tx_map_reg;
            out_used_reg  <= out_used_next;
            out_match_reg <= (out_used_next == tx_cnt_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_match_reg, out_used_reg,
                            out_map_reg[3], out_map_reg[2], out_map_reg[1], out_map_reg[0]};

    // no texel lands in two partitions; a_maps_cover checks each lands in one
    a_maps_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_map_reg[0] & out_map_reg[1]) == '0
                        && (out_map_reg[0] & out_map_reg[2]) == '0
                        && (out_map_reg[0] & out_map_reg[3]) == '0
                        && (out_map_reg[1] & out_map_reg[2]) == '0
                        && (out_map_reg[1] & out_map_reg[3]) == '0
                        && (out_map_reg[2] & out_map_reg[3]) == '0))
        else $error("partition maps overlap");

    a_maps_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_map_reg[0] | out_map_reg[1] | out_map_reg[2]
                            | out_map_reg[3]) == apbg_pkg::MAP_COVER))
        else $error("texel missing from all maps");

    // the first empty partition has an empty map
    a_used_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_used_reg != 3'd0 || out_map_reg[0] == '0)
                        && (out_used_reg != 3'd1 || out_map_reg[1] == '0)
                        && (out_used_reg != 3'd2 || out_map_reg[2] == '0)
                        && (out_used_reg != 3'd3 || out_map_reg[3] == '0)))
        else $error("used_parts disagrees with maps");

    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_used_reg <= 3'd4 && (!out_match_reg || out_used_reg != 3'd0)))
        else $error("used_parts out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
